FILE: design/stts_pkg.sv
package stts_pkg;

   localparam int ENTRIES_DEF     = 32;
   localparam int HANDLE_BITS_DEF = 16;
   localparam logic [31:0] NEXT_EVENT_RESET = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      ACT_CHECK      = 3'd0,
      ACT_REG_PERIOD = 3'd1,
      ACT_REG_ONCE   = 3'd2,
      ACT_UNREG      = 3'd3,
      ACT_CLEAR      = 3'd4
   } action_type;

   localparam logic KIND_FIRED   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic [2:0]  action;
      logic [31:0] now_ms;
      logic [31:0] delay_ms;
      logic [31:0] entry_id;
      logic [15:0] handle;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] out_id;
      logic [15:0] out_handle;
      logic        ok;
      logic        last;
   } rsp_type;

endpackage

FILE: design/stts_table.sv
module stts_table #(
   parameter int ENTRIES     = stts_pkg::ENTRIES_DEF,
   parameter int HANDLE_BITS = stts_pkg::HANDLE_BITS_DEF,
   localparam int AW = $clog2(ENTRIES),
   localparam int EW = 97 + HANDLE_BITS
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [EW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [EW-1:0] rd_data
);

   logic [EW-1:0] mem [ENTRIES];
   logic [EW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/software_timer_scheduler_table_top.sv
// Timer table scheduler. Entries live in one synchronous RAM (one write and
// one read port, registered read data), walked by a sequencer one slot at a
// time. A register, clear or unknown action goes straight to the summary; an
// unregister reads the used slots in turn until the id matches or they run
// out; a check at or past the stored minimum runs a fire scan over the used
// slots and then a compaction, each slot access costing a RAM read turnaround and each slot
// move a re-read of the filled slot. Fired items are emitted
// one by one during the scan, with a single output register; the scan
// pauses while that register is full and not taken. A summary item with
// last set closes every request.
module software_timer_scheduler_table_top #(
   parameter int ENTRIES     = stts_pkg::ENTRIES_DEF,
   parameter int HANDLE_BITS = stts_pkg::HANDLE_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  stts_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output stts_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int EW = 97 + HANDLE_BITS;
   localparam logic [CW-1:0] FULL = CW'(ENTRIES);

   typedef struct packed {
      logic                   dead;
      logic [31:0]            uid;
      logic [31:0]            due;
      logic [31:0]            period;
      logic [HANDLE_BITS-1:0] hnd;
   } ent_type;

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN_RD, S_SCAN, S_CMP_INIT, S_CMP_RDLO, S_CMP_LO,
      S_CMP_RDHI, S_CMP_HI, S_UNREG_RD, S_UNREG, S_CLEAR, S_SUM
   } state_type;

   state_type         state_ff;
   stts_pkg::req_type req_ff;
   logic [CW-1:0]     used_ff;
   logic [31:0]       next_event_ff;
   logic [31:0]       next_uid_ff;
   logic [AW-1:0]     idx_ff;
   logic [AW-1:0]     lo_ff;
   logic [AW-1:0]     hi_ff;
   ent_type           lo_ent_ff;
   logic              ok_ff;
   logic [31:0]       sum_id_ff;
   logic              rsp_valid_ff;
   stts_pkg::rsp_type rsp_ff;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   ent_type       wr_ent;
   logic [AW-1:0] rd_addr;
   logic [EW-1:0] rd_raw;
   ent_type       rd_ent;
   logic          out_free;

   stts_table #(.ENTRIES(ENTRIES), .HANDLE_BITS(HANDLE_BITS)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (EW'(wr_ent)),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_ent    = ent_type'(rd_raw);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   logic [31:0] scan_due;
   logic        scan_fire;
   logic        scan_dead;
   always_comb begin
      scan_fire = (req_ff.now_ms > rd_ent.due) && !rd_ent.dead;
      scan_due  = rd_ent.due;
      scan_dead = rd_ent.dead;
      if (scan_fire) begin
         if (rd_ent.period == 32'd0) begin
            scan_due  = 32'd0;
            scan_dead = 1'b1;
         end else begin
            scan_due = req_ff.now_ms + rd_ent.period;
         end
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_ent  = rd_ent;
      rd_addr = idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            wr_addr       = used_ff[AW-1:0];
            wr_ent.dead   = 1'b0;
            wr_ent.uid    = next_uid_ff;
            wr_ent.due    = req_data.now_ms + req_data.delay_ms;
            wr_ent.period = (req_data.action == stts_pkg::ACT_REG_PERIOD)
                            ? req_data.delay_ms : 32'd0;
            wr_ent.hnd    = HANDLE_BITS'(req_data.handle);
            wr_en = req_valid && used_ff < FULL
                    && (req_data.action == stts_pkg::ACT_REG_PERIOD
                        || req_data.action == stts_pkg::ACT_REG_ONCE);
         end
         S_SCAN: begin
            wr_en       = scan_fire && out_free;
            wr_ent.due  = scan_due;
            wr_ent.dead = scan_dead;
         end
         S_CMP_RDLO: rd_addr = lo_ff;
         S_CMP_RDHI: rd_addr = hi_ff;
         S_CMP_HI: begin
            // move live hi entry down into dead lo slot
            wr_addr = lo_ff;
            wr_en   = lo_ent_ff.dead && !rd_ent.dead && lo_ff < hi_ff;
         end
         S_UNREG: begin
            wr_ent.dead = 1'b1;
            wr_en       = rd_ent.uid == req_ff.entry_id;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         used_ff       <= '0;
         next_event_ff <= stts_pkg::NEXT_EVENT_RESET;
         next_uid_ff   <= 32'd1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  req_ff    <= req_data;
                  ok_ff     <= 1'b0;
                  sum_id_ff <= '0;
                  idx_ff    <= '0;
                  state_ff  <= S_SUM;
                  unique case (req_data.action)
                     stts_pkg::ACT_CHECK: begin
                        if (req_data.now_ms >= next_event_ff && used_ff != '0) begin
                           state_ff <= S_SCAN_RD;
                        end
                     end
                     stts_pkg::ACT_REG_PERIOD, stts_pkg::ACT_REG_ONCE: begin
                        if (used_ff < FULL) begin
                           used_ff     <= used_ff + 1'b1;
                           next_uid_ff <= next_uid_ff + 32'd1;
                           sum_id_ff   <= next_uid_ff;
                           ok_ff       <= 1'b1;
                           if (wr_ent.due < next_event_ff) begin
                              next_event_ff <= wr_ent.due;
                           end
                        end
                     end
                     stts_pkg::ACT_UNREG: begin
                        if (req_data.entry_id != 32'd0 && used_ff != '0) begin
                           state_ff <= S_UNREG_RD;
                        end
                     end
                     stts_pkg::ACT_CLEAR: used_ff <= '0;
                     default: ;
                  endcase
               end
            end
            S_SCAN_RD: state_ff <= S_SCAN;
            S_SCAN: begin
               if (!scan_fire || out_free) begin
                  if (scan_fire) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_ff <= '{kind: stts_pkg::KIND_FIRED, out_id: rd_ent.uid,
                                 out_handle: 16'(rd_ent.hnd), ok: 1'b1, last: 1'b0};
                  end
                  if (!scan_dead && scan_due < next_event_ff) begin
                     next_event_ff <= scan_due;
                  end
                  if ({1'b0, idx_ff} == used_ff - 1'b1) begin
                     state_ff <= S_CMP_INIT;
                  end else begin
                     idx_ff   <= idx_ff + 1'b1;
                     state_ff <= S_SCAN_RD;
                  end
               end
            end
            S_CMP_INIT: begin
               lo_ff    <= '0;
               hi_ff    <= AW'(used_ff - 1'b1);
               state_ff <= S_CMP_RDLO;
            end
            S_CMP_RDLO: state_ff <= S_CMP_LO;
            S_CMP_LO: begin
               lo_ent_ff <= rd_ent;
               if (lo_ff >= hi_ff) begin
                  if (rd_ent.dead) begin
                     used_ff <= CW'(lo_ff);
                  end
                  state_ff <= S_SUM;
               end else if (!rd_ent.dead) begin
                  lo_ff    <= lo_ff + 1'b1;
                  state_ff <= S_CMP_RDLO;
               end else begin
                  state_ff <= S_CMP_RDHI;
               end
            end
            S_CMP_RDHI: state_ff <= S_CMP_HI;
            S_CMP_HI: begin
               hi_ff <= hi_ff - 1'b1;
               if (!rd_ent.dead) begin
                  used_ff   <= CW'(hi_ff);
                  lo_ent_ff <= rd_ent;
                  // slot lo now live, re-examine it
                  state_ff  <= S_CMP_RDLO;
               end else if (lo_ff >= hi_ff - 1'b1) begin
                  // lo still dead and pointers meet
                  used_ff  <= CW'(lo_ff);
                  state_ff <= S_SUM;
               end else begin
                  state_ff <= S_CMP_RDHI;
               end
            end
            S_UNREG_RD: state_ff <= S_UNREG;
            S_UNREG: begin
               if (rd_ent.uid == req_ff.entry_id) begin
                  ok_ff    <= 1'b1;
                  state_ff <= S_SUM;
               end else if ({1'b0, idx_ff} == used_ff - 1'b1) begin
                  state_ff <= S_SUM;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_UNREG_RD;
               end
            end
            S_CLEAR: state_ff <= S_SUM;
            S_SUM: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff <= '{kind: stts_pkg::KIND_SUMMARY, out_id: sum_id_ff,
                              out_handle: 16'd0, ok: ok_ff, last: 1'b1};
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

FILE: design/stts_checker.sv
module stts_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input stts_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input stts_pkg::rsp_type rsp_data
);

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("request item changed while waiting");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   a_fired_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == stts_pkg::KIND_FIRED |-> rsp_data.ok && !rsp_data.last)
      else $error("fired item malformed");

   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == stts_pkg::KIND_SUMMARY
      |-> rsp_data.last && rsp_data.out_handle == 16'd0)
      else $error("summary item malformed");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted twice in a row");

endmodule

bind software_timer_scheduler_table_top stts_checker u_stts_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
